// ===== rtl/core/p2r7s_pkg.sv =====
// ---------------------------------------------------------------------------
// p2r7s_pkg: shared types and codes of the tachometer display block
// Control word layout, datapath operation codes, jump conditions, opcodes.
// ---------------------------------------------------------------------------
`default_nettype none

package p2r7s_pkg;

  localparam int NumDigitsDefault = 4;
  localparam logic [31:0] TpmReset = 32'd60000000;
  localparam logic [13:0] SpeedMax = 14'd9999;

  localparam int StepW = 4;

  // input opcodes
  localparam logic [1:0] OPC_OVERFLOW = 2'd0;
  localparam logic [1:0] OPC_CAPTURE  = 2'd1;
  localparam logic [1:0] OPC_SCAN     = 2'd2;

  // datapath operations
  localparam logic [2:0] DP_NOP      = 3'd0;
  localparam logic [2:0] DP_LATCH    = 3'd1;
  localparam logic [2:0] DP_DIV_INIT = 3'd2;
  localparam logic [2:0] DP_DIV_STEP = 3'd3;
  localparam logic [2:0] DP_SAT_LOAD = 3'd4;
  localparam logic [2:0] DP_BCD_STEP = 3'd5;
  localparam logic [2:0] DP_APPLY    = 3'd6;
  localparam logic [2:0] DP_EMIT     = 3'd7;

  // jump conditions
  localparam logic [2:0] JC_NEVER       = 3'd0;
  localparam logic [2:0] JC_ALWAYS      = 3'd1;
  localparam logic [2:0] JC_NO_IN       = 3'd2;
  localparam logic [2:0] JC_NOT_CAPTURE = 3'd3;
  localparam logic [2:0] JC_CNT_NZ      = 3'd4;
  localparam logic [2:0] JC_OUT_BLOCKED = 3'd5;

  // program steps
  localparam logic [StepW-1:0] ST_FETCH    = 4'd0;
  localparam logic [StepW-1:0] ST_DISPATCH = 4'd1;
  localparam logic [StepW-1:0] ST_DIV_INIT = 4'd2;
  localparam logic [StepW-1:0] ST_DIV_LOOP = 4'd3;
  localparam logic [StepW-1:0] ST_SAT      = 4'd4;
  localparam logic [StepW-1:0] ST_BCD_LOOP = 4'd5;
  localparam logic [StepW-1:0] ST_APPLY    = 4'd6;
  localparam logic [StepW-1:0] ST_EMIT     = 4'd7;
  localparam logic [StepW-1:0] ST_RETURN   = 4'd8;

  typedef struct packed {
    logic [2:0]       dp_op;
    logic [2:0]       cond;
    logic [StepW-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic cnt_nz;
    logic is_capture;
    logic out_blocked;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/period_to_rpm_seven_segment.sv =====
// ---------------------------------------------------------------------------
// period_to_rpm_seven_segment: tachometer with multiplexed seven-segment view
// Counts timer overflows, turns a capture into rpm by serial division and
// drives one digit of a multiplexed display per result beat.
// ---------------------------------------------------------------------------
//
//   channel   handshake              payload
//   -------   --------------------   -------------------------------------
//   in        in_valid / in_ready    opcode, capture_value
//   out       out_valid / out_ready  rpm_value, segments, digit_select
//   cfg       cfg_valid / cfg_ready  cfg_data (ticks per minute)
//
// overflow, scan and unused opcodes pass through the dispatch, apply and emit
//   steps; the result beat is registered in the emit step
// a capture runs dispatch, divide init, the divide loop, saturation, the bcd
//   loop, apply and emit: 32 restoring divide steps plus 14 bcd steps of the
//   datapath with its shared loop counter, run by the microcode step counter
// one item is in work at a time; in_ready is high only in the fetch step
// a result waits in the output register; the emit step holds while it is full and out_ready is low
// synchronous reset clears state, speed and display; cfg is always ready
`default_nettype none

module period_to_rpm_seven_segment #(
  parameter int NUM_DIGITS = p2r7s_pkg::NumDigitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // item input
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [15:0] capture_value,
  // result output
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [13:0]      rpm_value,
  output logic [6:0]       segments,
  output logic [3:0]       digit_select,
  // configuration write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  logic [p2r7s_pkg::StepW-1:0] step;
  p2r7s_pkg::ctrl_word_t       cw;
  p2r7s_pkg::dp_status_t       status;
  logic                        in_beat;
  logic                        cfg_beat;

  // input beats are only taken in the fetch step
  assign in_ready  = (step == p2r7s_pkg::ST_FETCH);
  assign in_beat   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_beat  = cfg_valid && cfg_ready;

  // control program
  p2r7s_ucode_rom u_rom (
    .step (step),
    .cw   (cw)
  );

  // step counter and jump logic
  p2r7s_sequencer u_seq (
    .clk     (clk),
    .rst     (rst),
    .cw      (cw),
    .status  (status),
    .in_beat (in_beat),
    .step    (step)
  );

  // divider, bcd conversion, state and output register
  p2r7s_datapath #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .dp_op         (cw.dp_op),
    .in_beat       (in_beat),
    .opcode        (opcode),
    .capture_value (capture_value),
    .cfg_beat      (cfg_beat),
    .cfg_data      (cfg_data),
    .out_ready     (out_ready),
    .status        (status),
    .out_valid     (out_valid),
    .rpm_value     (rpm_value),
    .segments      (segments),
    .digit_select  (digit_select)
  );

  // speed is always saturated
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rpm_value <= p2r7s_pkg::SpeedMax)
    else $error("rpm above saturation");

  // at most one digit driven
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(digit_select))
    else $error("digit select not one-hot");

  // an accepted item leaves the fetch step
  assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !in_ready)
    else $error("second beat taken while item in work");

  // a new result appears only from the emit step
  assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) && (step != p2r7s_pkg::ST_EMIT) |=> !out_valid)
    else $error("result produced outside emit step");

endmodule

`default_nettype wire

// ===== rtl/core/p2r7s_ucode_rom.sv =====
// ---------------------------------------------------------------------------
// p2r7s_ucode_rom: control program of the tachometer sequencer
// One control word per step: datapath operation, jump condition, target.
// ---------------------------------------------------------------------------
`default_nettype none

module p2r7s_ucode_rom (
  input  wire logic [p2r7s_pkg::StepW-1:0] step,
  output p2r7s_pkg::ctrl_word_t            cw
);

  always_comb begin
    case (step)
      p2r7s_pkg::ST_FETCH: begin
        cw = '{p2r7s_pkg::DP_LATCH, p2r7s_pkg::JC_NO_IN, p2r7s_pkg::ST_FETCH};
      end
      p2r7s_pkg::ST_DISPATCH: begin
        cw = '{p2r7s_pkg::DP_NOP, p2r7s_pkg::JC_NOT_CAPTURE, p2r7s_pkg::ST_APPLY};
      end
      p2r7s_pkg::ST_DIV_INIT: begin
        cw = '{p2r7s_pkg::DP_DIV_INIT, p2r7s_pkg::JC_NEVER, p2r7s_pkg::ST_FETCH};
      end
      p2r7s_pkg::ST_DIV_LOOP: begin
        cw = '{p2r7s_pkg::DP_DIV_STEP, p2r7s_pkg::JC_CNT_NZ, p2r7s_pkg::ST_DIV_LOOP};
      end
      p2r7s_pkg::ST_SAT: begin
        cw = '{p2r7s_pkg::DP_SAT_LOAD, p2r7s_pkg::JC_NEVER, p2r7s_pkg::ST_FETCH};
      end
      p2r7s_pkg::ST_BCD_LOOP: begin
        cw = '{p2r7s_pkg::DP_BCD_STEP, p2r7s_pkg::JC_CNT_NZ, p2r7s_pkg::ST_BCD_LOOP};
      end
      p2r7s_pkg::ST_APPLY: begin
        cw = '{p2r7s_pkg::DP_APPLY, p2r7s_pkg::JC_NEVER, p2r7s_pkg::ST_FETCH};
      end
      p2r7s_pkg::ST_EMIT: begin
        cw = '{p2r7s_pkg::DP_EMIT, p2r7s_pkg::JC_OUT_BLOCKED, p2r7s_pkg::ST_EMIT};
      end
      default: begin
        cw = '{p2r7s_pkg::DP_NOP, p2r7s_pkg::JC_ALWAYS, p2r7s_pkg::ST_FETCH};
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/p2r7s_sequencer.sv =====
// ---------------------------------------------------------------------------
// p2r7s_sequencer: step counter with conditional jumps
// Takes the jump target when the condition holds, else goes to the next step.
// ---------------------------------------------------------------------------
`default_nettype none

module p2r7s_sequencer (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire p2r7s_pkg::ctrl_word_t       cw,
  input  wire p2r7s_pkg::dp_status_t       status,
  input  wire logic                        in_beat,
  output logic [p2r7s_pkg::StepW-1:0]      step
);

  logic                           take;
  logic [p2r7s_pkg::StepW-1:0]    step_next;

  always_comb begin
    case (cw.cond)
      p2r7s_pkg::JC_ALWAYS:      take = 1'b1;
      p2r7s_pkg::JC_NO_IN:       take = !in_beat;
      p2r7s_pkg::JC_NOT_CAPTURE: take = !status.is_capture;
      p2r7s_pkg::JC_CNT_NZ:      take = status.cnt_nz;
      p2r7s_pkg::JC_OUT_BLOCKED: take = status.out_blocked;
      default:                   take = 1'b0;
    endcase
    step_next = take ? cw.target : step + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= p2r7s_pkg::ST_FETCH;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/p2r7s_datapath.sv =====
// ---------------------------------------------------------------------------
// p2r7s_datapath: state, serial divider, binary to bcd and output register
// Executes one datapath operation per cycle as the control word selects.
// ---------------------------------------------------------------------------
`default_nettype none

module p2r7s_datapath #(
  parameter int NUM_DIGITS = p2r7s_pkg::NumDigitsDefault
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [2:0]            dp_op,
  input  wire logic                  in_beat,
  input  wire logic [1:0]            opcode,
  input  wire logic [15:0]           capture_value,
  input  wire logic                  cfg_beat,
  input  wire logic [31:0]           cfg_data,
  input  wire logic                  out_ready,
  output p2r7s_pkg::dp_status_t      status,
  output logic                       out_valid,
  output logic [13:0]                rpm_value,
  output logic [6:0]                 segments,
  output logic [3:0]                 digit_select
);

  localparam int PosW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  function automatic logic [6:0] seg_of(input logic [3:0] d);
    case (d)
      4'd0:    seg_of = 7'h3F;
      4'd1:    seg_of = 7'h06;
      4'd2:    seg_of = 7'h5B;
      4'd3:    seg_of = 7'h4F;
      4'd4:    seg_of = 7'h66;
      4'd5:    seg_of = 7'h6D;
      4'd6:    seg_of = 7'h7D;
      4'd7:    seg_of = 7'h07;
      4'd8:    seg_of = 7'h7F;
      4'd9:    seg_of = 7'h6F;
      default: seg_of = 7'h00;
    endcase
  endfunction

  logic [31:0]     tpm;
  logic [15:0]     ovf;
  logic [13:0]     speed;
  logic [15:0]     digits;
  logic [PosW-1:0] pos;
  logic [1:0]      op_q;
  logic [15:0]     cap_q;
  logic [32:0]     rem;
  logic [31:0]     dq;
  logic [4:0]      cnt;
  logic            zero_per;
  logic [13:0]     bin;

  logic [31:0] period;
  logic [32:0] trial;
  logic        fits;
  logic [13:0] sat;
  logic [15:0] adj;
  logic [2:0]  pos3;
  logic [2:0]  weight;
  logic [3:0]  digit;
  logic [3:0]  sel;
  logic        out_blocked;

  always_comb begin
    period = {ovf, cap_q};
    trial  = {rem[31:0], dq[31]};
    fits   = trial >= {1'b0, period};
    sat    = (zero_per || dq > 32'(p2r7s_pkg::SpeedMax)) ? p2r7s_pkg::SpeedMax : dq[13:0];
    // add three to every bcd digit of five or more before the shift
    for (int i = 0; i < 4; i++) begin
      adj[i*4 +: 4] = (digits[i*4 +: 4] >= 4'd5) ? digits[i*4 +: 4] + 4'd3
                                                 : digits[i*4 +: 4];
    end
    pos3   = 3'(pos);
    weight = 3'(NUM_DIGITS - 1) - pos3;
    digit  = weight[2] ? 4'd0 : digits[{weight[1:0], 2'b00} +: 4];
    for (int i = 0; i < 4; i++) begin
      sel[i] = (pos3 == 3'(i));
    end
    out_blocked = out_valid && !out_ready;
  end

  assign status.cnt_nz      = (cnt != 5'd0);
  assign status.is_capture  = (op_q == p2r7s_pkg::OPC_CAPTURE);
  assign status.out_blocked = out_blocked;

  always_ff @(posedge clk) begin
    if (rst) begin
      tpm       <= p2r7s_pkg::TpmReset;
      ovf       <= '0;
      speed     <= '0;
      digits    <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_beat) begin
        tpm <= cfg_data;
      end
      // the emit step reloads the register itself when the beat is taken
      if (out_valid && out_ready && dp_op != p2r7s_pkg::DP_EMIT) begin
        out_valid <= 1'b0;
      end
      case (dp_op)
        p2r7s_pkg::DP_LATCH: begin
          if (in_beat) begin
            op_q  <= opcode;
            cap_q <= capture_value;
          end
        end
        p2r7s_pkg::DP_DIV_INIT: begin
          rem      <= '0;
          dq       <= tpm;
          cnt      <= 5'd31;
          zero_per <= (period == 32'd0);
        end
        p2r7s_pkg::DP_DIV_STEP: begin
          rem <= fits ? trial - {1'b0, period} : trial;
          dq  <= {dq[30:0], fits};
          cnt <= cnt - 5'd1;
        end
        p2r7s_pkg::DP_SAT_LOAD: begin
          speed  <= sat;
          bin    <= sat;
          digits <= '0;
          ovf    <= '0;
          cnt    <= 5'd13;
        end
        p2r7s_pkg::DP_BCD_STEP: begin
          digits <= {adj[14:0], bin[13]};
          bin    <= {bin[12:0], 1'b0};
          cnt    <= cnt - 5'd1;
        end
        p2r7s_pkg::DP_APPLY: begin
          if (op_q == p2r7s_pkg::OPC_OVERFLOW) begin
            if (ovf != 16'hFFFF) begin
              ovf <= ovf + 16'd1;
            end
          end else if (op_q == p2r7s_pkg::OPC_SCAN) begin
            pos <= (pos3 == 3'(NUM_DIGITS - 1)) ? '0 : pos + 1'b1;
          end
        end
        p2r7s_pkg::DP_EMIT: begin
          if (!out_blocked) begin
            out_valid    <= 1'b1;
            rpm_value    <= speed;
            segments     <= seg_of(digit);
            digit_select <= sel;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench: self-checking bench of the tachometer seven-segment block
// Drives overflow, capture, scan and unused events with random gaps on both sides,
// predicts speed, segment pattern and digit select per event, and checks
// every result beat in order across several ticks-per-minute settings.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int NumDigits = p2r7s_pkg::NumDigitsDefault;
  localparam logic [1:0] OpcUnused = 2'd3;
  localparam int CycleLimit = 400000;

  // segment patterns for digits 0..9, bit0 is segment a
  localparam logic [6:0] DigitSegments [0:9] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  typedef struct {
    logic [1:0]  opcode;
    logic [15:0] capture;
  } tach_event_t;

  typedef struct {
    logic [13:0] rpm;
    logic [6:0]  seg;
    logic [3:0]  sel;
  } display_reading_t;

  // clock, reset and block inputs, all known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [1:0]  opcode = p2r7s_pkg::OPC_OVERFLOW;
  logic [15:0] capture_value = 16'd0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [31:0] cfg_data = 32'd0;

  logic        in_ready;
  logic        out_valid;
  logic [13:0] rpm_value;
  logic [6:0]  segments;
  logic [3:0]  digit_select;
  logic        cfg_ready;

  period_to_rpm_seven_segment #(
    .NUM_DIGITS(NumDigits)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .capture_value(capture_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .rpm_value    (rpm_value),
    .segments     (segments),
    .digit_select (digit_select),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // tachometer predictor: own copy of the block state and its register
  // ------------------------------------------------------------------------
  logic [31:0] tach_ticks_per_min = p2r7s_pkg::TpmReset;
  logic [15:0] tach_overflows = 16'd0;
  logic [13:0] tach_speed = 14'd0;
  int          tach_scan_pos = 0;

  tach_event_t      pending_events[$];
  display_reading_t expected_readings[$];

  int events_queued = 0;
  int readings_seen = 0;
  int mismatch_count = 0;
  logic idle_enabled = 1'b1;
  logic hold_off = 1'b0;

  // update the predicted state with one accepted event, queue its reading
  function void predict_reading(input logic [1:0] op, input logic [15:0] cap);
    logic [47:0] period;
    logic [47:0] quotient;
    int unsigned weight;
    int unsigned digit;
    display_reading_t r;
    case (op)
      p2r7s_pkg::OPC_OVERFLOW: begin
        // counter saturates at all ones
        if (tach_overflows != 16'hFFFF) tach_overflows = tach_overflows + 16'd1;
      end
      p2r7s_pkg::OPC_CAPTURE: begin
        period = {16'd0, tach_overflows, cap};
        if (period == 48'd0) begin
          quotient = 48'(p2r7s_pkg::SpeedMax);   // zero period reads as top speed
        end else begin
          quotient = {16'd0, tach_ticks_per_min} / period;
        end
        if (quotient > 48'(p2r7s_pkg::SpeedMax)) quotient = 48'(p2r7s_pkg::SpeedMax);
        tach_speed = quotient[13:0];
        tach_overflows = 16'd0;
      end
      p2r7s_pkg::OPC_SCAN: begin
        tach_scan_pos = (tach_scan_pos >= NumDigits - 1) ? 0 : tach_scan_pos + 1;
      end
      default: begin
        // unused opcode leaves the state alone
      end
    endcase
    // position 0 shows the most significant digit
    weight = 1;
    for (int i = 0; i < NumDigits - 1 - tach_scan_pos; i++) weight = weight * 10;
    digit = (int'(tach_speed) / weight) % 10;
    r.rpm = tach_speed;
    r.seg = DigitSegments[digit];
    r.sel = (tach_scan_pos < 4) ? 4'(1 << tach_scan_pos) : 4'd0;
    expected_readings.push_back(r);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch: %s", what);
  endtask

  // gap before the next beat of one side, none at all when idling is off
  function automatic int draw_gap();
    if (!idle_enabled) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  // ------------------------------------------------------------------------
  // input driver: offers queued events, one beat each
  // ------------------------------------------------------------------------
  int          drv_gap = 0;
  logic        drv_next_valid;
  tach_event_t drv_event;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      drv_gap = 0;
    end else begin
      drv_next_valid = in_valid;
      if (in_valid && in_ready) begin
        // beat taken: predict from the payload that was on the wires
        predict_reading(opcode, capture_value);
        drv_next_valid = 1'b0;
        drv_gap = draw_gap();
      end
      if (!drv_next_valid) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (pending_events.size() > 0) begin
          drv_event = pending_events.pop_front();
          opcode <= drv_event.opcode;
          capture_value <= drv_event.capture;
          drv_next_valid = 1'b1;
        end
      end
      // valid is assigned once per edge so a back-to-back beat keeps it high
      in_valid <= drv_next_valid;
    end
  end

  // ------------------------------------------------------------------------
  // result monitor: random ready, compares each beat with the oldest reading
  // ------------------------------------------------------------------------
  int               rcv_gap = 0;
  logic             rcv_next_ready;
  display_reading_t rcv_want;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rcv_gap = 0;
    end else begin
      rcv_next_ready = out_ready;
      if (out_valid && out_ready) begin
        readings_seen++;
        if (expected_readings.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected, rpm %0d", rpm_value));
        end else begin
          rcv_want = expected_readings.pop_front();
          if (rpm_value !== rcv_want.rpm)
            report_mismatch($sformatf("rpm_value %0d, want %0d", rpm_value, rcv_want.rpm));
          if (segments !== rcv_want.seg)
            report_mismatch($sformatf("segments %h, want %h", segments, rcv_want.seg));
          if (digit_select !== rcv_want.sel)
            report_mismatch($sformatf("digit_select %b, want %b", digit_select,
                                      rcv_want.sel));
        end
        rcv_next_ready = 1'b0;
        rcv_gap = draw_gap();
      end
      if (!rcv_next_ready) begin
        if (rcv_gap > 0) rcv_gap--;
        else rcv_next_ready = 1'b1;
      end
      // a long hold-off backs the block up until it stalls its input
      out_ready <= hold_off ? 1'b0 : rcv_next_ready;
    end
  end

  // long receiver stall, counted in its own cycles
  int hold_cycles = 0;

  always @(posedge clk) begin
    if (rst) begin
      hold_cycles <= 0;
      hold_off <= 1'b0;
    end else begin
      hold_cycles <= hold_cycles + 1;
      hold_off <= ((hold_cycles % 5000) >= 1200) && ((hold_cycles % 5000) < 1500);
    end
  end

  // watchdog
  int wd_cycles = 0;

  always @(posedge clk) begin
    wd_cycles++;
    if (wd_cycles >= CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------------
  task automatic queue_event(input logic [1:0] op, input logic [15:0] cap);
    tach_event_t e;
    e.opcode = op;
    e.capture = cap;
    pending_events.push_back(e);
    events_queued++;
  endtask

  // mostly overflows-then-capture measurements with scans, some noise
  task automatic queue_random_traffic(input int count);
    int n;
    int ovfs;
    int scans;
    logic [15:0] cap;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) < 8) begin
        ovfs = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
        for (int i = 0; i < ovfs; i++) queue_event(p2r7s_pkg::OPC_OVERFLOW, 16'($urandom()));
        cap = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 15)) : 16'($urandom());
        queue_event(p2r7s_pkg::OPC_CAPTURE, cap);
        scans = $urandom_range(0, 5);
        for (int i = 0; i < scans; i++) queue_event(p2r7s_pkg::OPC_SCAN, 16'($urandom()));
        n += ovfs + 1 + scans;
      end else begin
        queue_event(2'($urandom_range(0, 3)), 16'($urandom()));
        n++;
      end
    end
  endtask

  // wait until every queued event has come back as a result beat
  task automatic wait_drained();
    while (readings_seen < events_queued) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // register write on the cfg channel, block idle
  task automatic write_ticks(input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tach_ticks_per_min = value;
  endtask

  task automatic set_idling(input logic on);
    @(posedge clk);
    idle_enabled <= on;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset rate
    queue_event(OpcUnused, 16'h0000);     // unused opcode after reset
    repeat (4) queue_event(p2r7s_pkg::OPC_SCAN, 16'h0000);   // full scan and wrap
    queue_event(p2r7s_pkg::OPC_CAPTURE, 16'h0000);   // zero period
    repeat (3) queue_event(p2r7s_pkg::OPC_SCAN, 16'hFFFF);
    queue_event(p2r7s_pkg::OPC_CAPTURE, 16'hFFFF);
    queue_event(p2r7s_pkg::OPC_OVERFLOW, 16'h0000);
    queue_event(p2r7s_pkg::OPC_CAPTURE, 16'h0000);   // exactly one overflow period
    queue_event(p2r7s_pkg::OPC_CAPTURE, 16'h0001);   // quotient far above the top
    queue_event(p2r7s_pkg::OPC_CAPTURE, 16'd6000);   // quotient just above the top
    queue_event(p2r7s_pkg::OPC_CAPTURE, 16'd6001);
    queue_event(p2r7s_pkg::OPC_SCAN, 16'h5555);
    queue_event(p2r7s_pkg::OPC_OVERFLOW, 16'hAAAA);
    queue_event(p2r7s_pkg::OPC_OVERFLOW, 16'hFFFF);
    queue_event(p2r7s_pkg::OPC_CAPTURE, 16'h1234);
    queue_event(OpcUnused, 16'hFFFF);
    queue_random_traffic(140);
    wait_drained();

    // smallest rate: speed is zero but for a period of one (speed one) and a zero period (top speed)
    write_ticks(32'd1);
    queue_random_traffic(90);
    wait_drained();

    // zero rate, zero period still reads as top speed
    write_ticks(32'd0);
    queue_event(p2r7s_pkg::OPC_CAPTURE, 16'h0000);
    queue_event(p2r7s_pkg::OPC_CAPTURE, 16'h0005);
    queue_random_traffic(80);
    wait_drained();

    // largest rate, a long overflow run back to back, then mixed traffic
    write_ticks(32'hFFFF_FFFF);
    set_idling(1'b0);
    repeat (20) queue_event(p2r7s_pkg::OPC_OVERFLOW, 16'($urandom()));
    queue_event(p2r7s_pkg::OPC_CAPTURE, 16'hFFFF);
    wait_drained();
    set_idling(1'b1);
    queue_random_traffic(140);
    wait_drained();

    write_ticks($urandom());
    queue_random_traffic(140);
    wait_drained();

    // back to the reset rate with no idling on either side
    write_ticks(p2r7s_pkg::TpmReset);
    set_idling(1'b0);
    queue_random_traffic(130);
    wait_drained();

    set_idling(1'b1);
    write_ticks($urandom_range(100000, 200000000));
    queue_random_traffic(90);
    wait_drained();

    // catch any late extra beat
    repeat (60) @(posedge clk);
    if (expected_readings.size() != 0)
      report_mismatch($sformatf("%0d readings never arrived", expected_readings.size()));

    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/p2r7s_pkg.sv
rtl/core/p2r7s_ucode_rom.sv
rtl/core/p2r7s_sequencer.sv
rtl/core/p2r7s_datapath.sv
rtl/core/period_to_rpm_seven_segment.sv
verif/testbench.sv
